FILE: design/prf_pkg.sv
// Shared types and constants for the polyphase resampling FIR.
`timescale 1ns / 1ps

package prf_pkg;

  // Operation codes carried by an input transaction.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TAP    = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_DECIMATION    = 2'd0;
  localparam logic [1:0] REG_INTERPOLATION = 2'd1;
  localparam logic [1:0] REG_TAP_COUNT     = 2'd2;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 32;
  localparam int VALUE_W  = 38;

  typedef struct packed {
    logic                       operation;
    logic signed [SAMPLE_W-1:0] sample;
    logic [5:0]                 tap_index;
    logic signed [SAMPLE_W-1:0] tap_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [3:0]                phase;
    logic                      last;
  } out_item_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;  // start a new sum
    logic vld;  // operand pair present this cycle
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_HOLD
  } state_t;

endpackage

FILE: design/polyphase_resampling_fir.sv
// Top level of the polyphase rational resampling FIR filter.
`timescale 1ns / 1ps
//
//   Channel | Ports                              | Transaction
//   --------+------------------------------------+--------------------------------------
//   input   | in_valid, in_ready, in_data        | one sample or one coefficient write
//   output  | out_valid, out_ready, out_data     | one filtered result of a burst
//   config  | cfg_valid, cfg_ready, cfg_index,   | one register write, always ready
//           | cfg_data                           |
//
// A coefficient write, or a sample that does not complete a burst, leaves in_ready high.
// A sample that completes a burst runs its phases in turn: each of
// the L phases streams its taps through the single multiply-accumulate unit, one term
// per cycle, and then drains its read, multiply and add stages.
// After reset a clearing pass over all MAX_TAPS entries loads the history and coefficient
// memories; in_ready stays low during it, while configuration writes are taken.
// A stalled output holds its result in the output register; the next phase waits.

module polyphase_resampling_fir
  import prf_pkg::*;
#(
  parameter int MAX_TAPS = 64,
  parameter int MAX_RATE = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_TAPS - 1);

  // Configuration registers and their effective values after clamping.
  logic [4:0] decimation_r;
  logic [4:0] interpolation_r;
  logic [6:0] tap_count_r;
  logic [4:0] m_eff;
  logic [4:0] l_eff;
  logic [6:0] t_eff;

  always_comb begin
    if (decimation_r == 5'd0) begin
      m_eff = 5'd1;
    end else if (32'(decimation_r) > MAX_RATE) begin
      m_eff = 5'(MAX_RATE);
    end else begin
      m_eff = decimation_r;
    end
    if (interpolation_r == 5'd0) begin
      l_eff = 5'd1;
    end else if (32'(interpolation_r) > MAX_RATE) begin
      l_eff = 5'(MAX_RATE);
    end else begin
      l_eff = interpolation_r;
    end
    if (tap_count_r == 7'd0) begin
      t_eff = 7'd1;
    end else if (32'(tap_count_r) > MAX_TAPS) begin
      t_eff = 7'(MAX_TAPS);
    end else begin
      t_eff = tap_count_r;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decimation_r    <= 5'd1;
      interpolation_r <= 5'd1;
      tap_count_r     <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DECIMATION:    decimation_r    <= cfg_data[4:0];
        REG_INTERPOLATION: interpolation_r <= cfg_data[4:0];
        REG_TAP_COUNT:     tap_count_r     <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Sequencer state and control registers.
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_idx_r;
  logic [ADDR_W-1:0] wp_r;        // address of the newest sample
  logic [ADDR_W-1:0] rp_r;        // history address of the next term
  logic [7:0]        ti_r;        // coefficient index of the next term
  logic [4:0]        j_r;         // phase in progress
  logic [6:0]        cnt_r;
  logic              primed_r;
  logic              rd_vld_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_accept;
  logic              sample_go;
  logic              tap_go;
  logic [6:0]        cnt_inc;
  logic [11:0]       span;
  logic              burst;
  logic [ADDR_W-1:0] wp_inc;
  logic              issue;
  logic              mac_busy;
  logic              mac_done;
  logic              slot_free;
  logic              last_phase;
  logic              finish;
  logic              out_load;
  logic              phase_start;
  mac_ctrl_t         mac_ctrl;
  logic signed [VALUE_W-1:0] mac_acc;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign sample_go = in_accept && (in_data.operation == OP_SAMPLE);
  assign tap_go    = in_accept && (in_data.operation == OP_TAP)
                     && (32'(in_data.tap_index) < MAX_TAPS);

  // The counter saturates; a burst is due once it reaches M, or before the first
  // burst once count * L covers the tap count, which equals count >= ceil(T / L).
  assign cnt_inc = (cnt_r == 7'd127) ? cnt_r : cnt_r + 7'd1;
  assign span    = 12'(cnt_inc) * 12'(l_eff);
  assign burst   = sample_go && (primed_r ? (cnt_inc >= 7'(m_eff))
                                          : (span >= 12'(t_eff)));
  assign wp_inc  = (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;

  assign slot_free  = !out_valid_r || out_ready;
  assign last_phase = (j_r == l_eff - 5'd1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_idx_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE:  if (burst) state_nxt = ST_MAC;
      ST_MAC, ST_HOLD: begin
        if (finish) begin
          if (!slot_free)      state_nxt = ST_HOLD;
          else if (last_phase) state_nxt = ST_IDLE;
          else                 state_nxt = ST_MAC;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Sequencer outputs. Terms stop once the coefficient index reaches or passes the tap
  // count, which also bounds the history depth reached.
  always_comb begin
    issue    = 1'b0;
    mac_done = 1'b0;
    finish   = 1'b0;
    unique case (state_r)
      ST_MAC: begin
        issue    = (ti_r < 8'(t_eff));
        mac_done = !issue && !rd_vld_r && !mac_busy;
        finish   = mac_done;
      end
      ST_HOLD: finish = 1'b1;
      default: ;
    endcase
    out_load    = finish && slot_free;
    phase_start = burst || (out_load && !last_phase);
  end

  assign mac_ctrl.clr = phase_start;
  assign mac_ctrl.vld = rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      primed_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (sample_go) begin
        wp_r <= wp_inc;
        if (burst) begin
          cnt_r    <= '0;
          primed_r <= 1'b1;
        end else begin
          cnt_r <= cnt_inc;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Term addressing: coefficient index steps by L, history steps back by one.
  always_ff @(posedge clk) begin
    if (burst) begin
      j_r  <= '0;
      ti_r <= '0;
      rp_r <= wp_inc;
    end else if (phase_start) begin
      j_r  <= j_r + 5'd1;
      ti_r <= 8'(j_r) + 8'd1;
      rp_r <= wp_r;
    end else if (issue) begin
      ti_r <= ti_r + 8'(l_eff);
      rp_r <= (rp_r == '0) ? LAST_ADDR : rp_r - 1'b1;
    end
    if (out_load) begin
      out_data_r.value <= mac_acc;
      out_data_r.phase <= j_r[3:0];
      out_data_r.last  <= last_phase;
    end
  end

  // History and coefficient memories; the clearing pass zeroes both and puts
  // a unit tap at entry zero.
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [SAMPLE_W-1:0] coef_q;
  logic                       clearing;

  assign clearing = (state_r == ST_CLEAR);

  always_ff @(posedge clk) begin
    if (clearing) begin
      hist_mem[clr_idx_r] <= '0;
    end else if (sample_go) begin
      hist_mem[wp_inc] <= in_data.sample;
    end
    hist_q <= hist_mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      coef_mem[clr_idx_r] <= (clr_idx_r == '0) ? SAMPLE_W'(1) : '0;
    end else if (tap_go) begin
      coef_mem[ADDR_W'(in_data.tap_index)] <= in_data.tap_value;
    end
    coef_q <= coef_mem[ADDR_W'(ti_r)];
  end

  prf_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (mac_ctrl),
    .coef (coef_q),
    .hist (hist_q),
    .acc  (mac_acc),
    .busy (mac_busy)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/prf_mac.sv
// Pipelined multiply-accumulate unit shared by every term of every phase.
`timescale 1ns / 1ps

module prf_mac
  import prf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctrl_t                  ctrl,
  input  logic signed [SAMPLE_W-1:0] coef,
  input  logic signed [SAMPLE_W-1:0] hist,
  output logic signed [VALUE_W-1:0]  acc,
  output logic                       busy
);

  logic signed [PROD_W-1:0]  prod_r;
  logic                      mul_vld_r;
  logic signed [VALUE_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= ctrl.vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= coef * hist;
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (mul_vld_r) begin
      acc_r <= acc_r + {{(VALUE_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign acc  = acc_r;
  assign busy = mul_vld_r;

endmodule

FILE: test/polyphase_resampling_fir_test.sv
// Self-checking testbench for the polyphase resampling FIR: directed table, then random phases.
`timescale 1ns / 1ps

module polyphase_resampling_fir_test;
  import prf_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 160;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int TAPS            = 64;
  localparam int RATE_CAP        = 16;

  // The register port is two bits wide; the last index selects no register.
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  in_item_t         in_data   = '0;
  logic             out_ready = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [1:0]       cfg_index = REG_DECIMATION;
  logic [6:0]       cfg_data  = '0;
  logic             in_ready;
  logic             out_valid;
  logic             cfg_ready;
  out_item_t        out_data;

  polyphase_resampling_fir dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Filter state as the testbench sees it. Registers hold the raw written bits;
  // the zero and oversize rules are applied when a burst is computed.
  // ---------------------------------------------------------------------------
  logic [4:0]         decim_r  = 5'd1;
  logic [4:0]         interp_r = 5'd1;
  logic [6:0]         taps_r   = 7'd1;
  logic signed [15:0] hist_mem [TAPS];
  logic signed [15:0] coef_mem [TAPS];
  int unsigned        since_burst = 0;
  bit                 primed      = 1'b0;

  // Filtered results that have been computed but not yet seen at the output.
  out_item_t filtered_q [$];

  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned n_items     = 0;
  int unsigned n_tap_items = 0;
  int unsigned n_results   = 0;
  int unsigned n_cfg       = 0;
  int unsigned n_settings  = 0;
  int unsigned burst_left  = 0;
  bit          hold_armed  = 1'b0;
  bit          hold_done   = 1'b0;

  initial begin
    for (int i = 0; i < TAPS; i++) begin
      hist_mem[i] = '0;
      coef_mem[i] = '0;
    end
    coef_mem[0] = 16'sd1;
  end

  function automatic int unsigned clamp_rate(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Applies one accepted input transaction to the filter state and queues the
  // burst of L results that it completes, if any.
  task automatic resample_item(input in_item_t it);
    int unsigned m, l, t, k_len, threshold, ti;
    longint      acc;
    out_item_t   r;
    if (it.operation == OP_TAP) begin
      coef_mem[it.tap_index] = it.tap_value;
      return;
    end
    for (int i = TAPS - 1; i > 0; i--) hist_mem[i] = hist_mem[i-1];
    hist_mem[0] = it.sample;
    if (since_burst < 127) since_burst++;

    m     = clamp_rate(decim_r, RATE_CAP);
    l     = clamp_rate(interp_r, RATE_CAP);
    t     = clamp_rate(taps_r, TAPS);
    k_len = (t + l - 1) / l;
    // Before the first burst the history must fill to K; after it, every M samples.
    threshold = primed ? m : k_len;
    if (since_burst < threshold) return;
    since_burst = 0;
    primed      = 1'b1;

    for (int j = 0; j < l; j++) begin
      acc = 0;
      for (int k = 0; k < k_len; k++) begin
        ti = j + k * l;
        if (ti < t) acc += longint'(coef_mem[ti]) * longint'(hist_mem[k]);
      end
      r.value = acc[VALUE_W-1:0];
      r.phase = j[3:0];
      r.last  = (j == l - 1);
      filtered_q.insert(filtered_q.size(), r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: check every accepted result against the oldest one queued.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (filtered_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d phase=%0d last=%0b", $time,
                 out_data.value, out_data.phase, out_data.last);
      end else begin
        want = filtered_q.pop_front();
        if (out_data.value !== want.value) begin
          errors++;
          $display("%0t: value mismatch expected %0d actual %0d", $time,
                   want.value, out_data.value);
        end
        if (out_data.phase !== want.phase) begin
          errors++;
          $display("%0t: phase mismatch expected %0d actual %0d", $time,
                   want.phase, out_data.phase);
        end
        if (out_data.last !== want.last) begin
          errors++;
          $display("%0t: last mismatch expected %0b actual %0b", $time,
                   want.last, out_data.last);
        end
      end
    end
  end

  // The receiver stalls in modes picked at random: always ready, coin flip,
  // mostly stalled, and a fixed on-off pattern. Once, when armed, it holds
  // off for a long stretch so that the block backs up and stalls its input.
  initial begin : receiver
    int unsigned tick, mode;
    tick = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      tick++;
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= tick[2];
      endcase
    end
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               filtered_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Transactions go out in bursts of random length separated by
  // random gaps; all driving happens at the falling edge. When a row carries a
  // typed expectation, that value replaces the computed one for its result.
  // ---------------------------------------------------------------------------
  task automatic offer(input in_item_t it, input bit typed,
                       input logic signed [VALUE_W-1:0] want);
    int unsigned gap;
    out_item_t   r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    resample_item(it);
    if (typed && filtered_q.size() != 0) begin
      r = filtered_q.pop_back();
      r.value = want;
      filtered_q.insert(filtered_q.size(), r);
    end
    n_items++;
    if (it.operation == OP_TAP) n_tap_items++;
    burst_left--;
    @(negedge clk);
  endtask

  // Lets every queued result drain, then waits out any burst still in flight
  // so that the block is idle before the registers change.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (filtered_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes decimation, interpolation and tap count back to back, and
  // optionally pokes the unused index, which must change nothing.
  task automatic set_rates(input logic [6:0] m, input logic [6:0] l,
                           input logic [6:0] t, input bit poke_spare);
    logic [1:0]  idx [4];
    logic [6:0]  dat [4];
    int unsigned n;
    idx[0] = REG_DECIMATION;    dat[0] = m;
    idx[1] = REG_INTERPOLATION; dat[1] = l;
    idx[2] = REG_TAP_COUNT;     dat[2] = t;
    idx[3] = REG_SPARE;         dat[3] = 7'h7F;
    n = poke_spare ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= dat[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        REG_DECIMATION:    decim_r  = dat[i][4:0];
        REG_INTERPOLATION: interp_r = dat[i][4:0];
        REG_TAP_COUNT:     taps_r   = dat[i];
        default: ;
      endcase
      n_cfg++;
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Full-scale values turn up often so that products hit their extremes.
  function automatic logic signed [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Unused fields of every transaction carry random bits.
  function automatic in_item_t make_item(input logic op, input logic signed [15:0] s,
                                         input logic [5:0] idx,
                                         input logic signed [15:0] v);
    in_item_t it;
    it.operation = op;
    it.sample    = (op == OP_SAMPLE) ? s : 16'($urandom);
    it.tap_index = (op == OP_TAP) ? idx : 6'($urandom);
    it.tap_value = (op == OP_TAP) ? v : 16'($urandom);
    return it;
  endfunction

  task automatic random_run(input int unsigned n);
    logic op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 3) == 0) ? OP_TAP : OP_SAMPLE;
      offer(make_item(op, pick_word(), 6'($urandom_range(0, 63)), pick_word()), 1'b0, '0);
    end
    settle();
  endtask

  typedef struct {
    in_item_t                  item;
    bit                        typed;
    logic signed [VALUE_W-1:0] want;
  } row_t;

  row_t plan [$];

  task automatic add_row(input logic op, input logic signed [15:0] s,
                         input logic [5:0] idx, input logic signed [15:0] v,
                         input bit typed, input logic signed [VALUE_W-1:0] want);
    row_t r;
    r.item  = make_item(op, s, idx, v);
    r.typed = typed;
    r.want  = want;
    plan.insert(plan.size(), r);
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Three taps at rate one: the first burst waits for three samples, and
    // with the reset coefficients each result is simply the newest sample.
    set_rates(7'd1, 7'd1, 7'd3, 1'b0);

    add_row(OP_SAMPLE, 16'sd100,    6'd0,  16'sd0,     1'b0, '0);
    add_row(OP_SAMPLE, -16'sd5,     6'd0,  16'sd0,     1'b0, '0);
    add_row(OP_SAMPLE, 16'sh7FFF,   6'd0,  16'sd0,     1'b1, 38'sd32767);
    add_row(OP_SAMPLE, 16'sh8000,   6'd0,  16'sd0,     1'b1, -38'sd32768);
    add_row(OP_TAP,    16'sd0,      6'd0,  16'sh8000,  1'b0, '0);
    // Most negative coefficient times most negative sample, then times the
    // largest positive sample; the other two taps are still zero.
    add_row(OP_SAMPLE, 16'sh8000,   6'd0,  16'sd0,     1'b1, 38'sd1073741824);
    add_row(OP_SAMPLE, 16'sh7FFF,   6'd0,  16'sd0,     1'b1, -38'sd1073709056);
    add_row(OP_TAP,    16'sd0,      6'd63, 16'sh5555,  1'b0, '0);
    add_row(OP_TAP,    16'sd0,      6'd1,  16'sh7FFF,  1'b0, '0);
    add_row(OP_TAP,    16'sd0,      6'd2,  -16'sd1,    1'b0, '0);
    add_row(OP_SAMPLE, 16'sd1,      6'd0,  16'sd0,     1'b0, '0);
    add_row(OP_SAMPLE, 16'sd0,      6'd0,  16'sd0,     1'b0, '0);
    add_row(OP_TAP,    16'sd0,      6'd42, 16'sh2AAA,  1'b0, '0);
    add_row(OP_TAP,    16'sd0,      6'd21, 16'shAAAA,  1'b0, '0);
    add_row(OP_SAMPLE, 16'sh5555,   6'd0,  16'sd0,     1'b0, '0);
    add_row(OP_SAMPLE, 16'shAAAA,   6'd0,  16'sd0,     1'b0, '0);
    add_row(OP_TAP,    16'sd0,      6'd0,  16'sd1,     1'b0, '0);
    add_row(OP_SAMPLE, -16'sd1,     6'd0,  16'sd0,     1'b0, '0);
    add_row(OP_SAMPLE, 16'sd12345,  6'd0,  16'sd0,     1'b0, '0);
    foreach (plan[i]) offer(plan[i].item, plan[i].typed, plan[i].want);
    settle();

    // Random phases; each register change lands on a history and counter that
    // carry over, so a lower threshold can release a burst on the next sample.
    set_rates(7'd2, 7'd3, 7'd10, 1'b1);
    random_run(30);

    // Decimation written above the cap with all bits set, largest L.
    set_rates(7'h7F, 7'd16, 7'd64, 1'b0);
    random_run(30);

    // Zero rates act as one and an oversized tap count as the full store.
    // Every coefficient and every history entry at full negative scale gives
    // the largest sum the filter can produce.
    set_rates(7'd0, 7'd0, 7'd127, 1'b0);
    for (int i = 0; i < TAPS; i++)
      offer(make_item(OP_TAP, 16'sd0, i[5:0], 16'sh8000), 1'b0, '0);
    for (int i = 0; i < TAPS; i++)
      offer(make_item(OP_SAMPLE, 16'sh8000, 6'd0, 16'sd0), i == TAPS - 1,
            38'sd68719476736);
    settle();

    // Interpolation just above the cap, zero tap count.
    set_rates(7'd3, 7'h51, 7'd0, 1'b0);
    random_run(30);

    // Sixteen results per sample while the receiver holds off for a while.
    set_rates(7'd1, 7'd16, 7'd64, 1'b0);
    hold_armed = 1'b1;
    random_run(30);

    // Largest decimation at rate one: bursts are rare.
    set_rates(7'd16, 7'd1, 7'd64, 1'b0);
    random_run(30);

    // Upper bits of the decimation write are dropped, leaving five.
    set_rates(7'h65, 7'd4, 7'd37, 1'b0);
    random_run(30);

    $display("Sent %0d input transactions (%0d coefficient writes), checked %0d results.",
             n_items, n_tap_items, n_results);
    $display("Made %0d register writes across %0d rate and tap settings, %0d errors.",
             n_cfg, n_settings, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
